FILE: rtl/core/tkts_pkg.sv
`timescale 1ns / 1ps

package tkts_pkg;

  // Width of the rank field on the result port.
  localparam int unsigned RANK_BITS = 4;

  // What a ranking cell does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_SHIFT_DOWN,
    CELL_SHIFT_UP
  } cell_mode_e;

  // Control states of the selector.
  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } sel_state_e;

endpackage

FILE: rtl/core/top_k_traffic_selector.sv
`timescale 1ns / 1ps
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+---------------------------------------------
// record in | start, busy (taken: start&!busy) | conn_id_i, counters, last_record_i
// result    | result_valid_o, no stall      | rank_o, ranked_id_o, ranked_key_o, flags
// config    | cfg_valid_i, cfg_ready_o      | cfg_key_select_i
//
// A record is ranked in the cycle it is taken, so one record per clock is accepted while busy is low.
// The record marked last is followed by the results, one slot per cycle, set by the
// chain of cells shifting toward its head; busy is high while the results go out.
// The shift-out leaves every cell empty, so the next batch starts clear.
// Reset empties all cells and sets the key select to the bit sum.
// Results cannot be stalled: each one is shown for exactly one cycle.

module top_k_traffic_selector
  import tkts_pkg::*;
#(
  parameter int unsigned TOP_K      = 10,
  parameter int unsigned ID_BITS    = 16,
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_key_select_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [ID_BITS-1:0]    conn_id_i,
  input  logic [COUNT_BITS-1:0] recv_packets_i,
  input  logic [COUNT_BITS-1:0] sent_packets_i,
  input  logic [COUNT_BITS-1:0] recv_bits_i,
  input  logic [COUNT_BITS-1:0] sent_bits_i,
  input  logic                  last_record_i,
  output logic                  result_valid_o,
  output logic [RANK_BITS-1:0]  rank_o,
  output logic [ID_BITS-1:0]    ranked_id_o,
  output logic [COUNT_BITS:0]   ranked_key_o,
  output logic                  slot_used_o,
  output logic                  last_slot_o
);

  localparam int unsigned KEY_BITS = COUNT_BITS + 1;
  localparam int unsigned CNT_BITS = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(TOP_K - 1);

  logic                key_select_q;
  sel_state_e          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                accept;
  logic                drain;
  logic [KEY_BITS-1:0] new_key;

  logic [KEY_BITS-1:0] cell_key   [TOP_K];
  logic [ID_BITS-1:0]  cell_id    [TOP_K];
  logic                cell_valid [TOP_K];
  logic                cell_take  [TOP_K];

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign drain       = (state_q == ST_DRAIN);
  assign busy        = drain;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_select_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_select_q <= cfg_key_select_i;
    end
  end

  // Ranking key: packet sum or bit sum, one bit wider than the counters.
  always_comb begin
    if (key_select_q) begin
      new_key = {1'b0, recv_packets_i} + {1'b0, sent_packets_i};
    end else begin
      new_key = {1'b0, recv_bits_i} + {1'b0, sent_bits_i};
    end
  end

  // Chain of cells, slot 0 at the head holding the largest key.
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    logic                prev_take;
    logic [KEY_BITS-1:0] prev_key, next_key;
    logic [ID_BITS-1:0]  prev_id, next_id;
    logic                prev_valid, next_valid;

    if (i == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_key   = '0;
      assign prev_id    = '0;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_take  = cell_take[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_id    = cell_id[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == TOP_K - 1) begin : g_tail
      assign next_key   = '0;
      assign next_id    = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_key   = cell_key[i+1];
      assign next_id    = cell_id[i+1];
      assign next_valid = cell_valid[i+1];
    end

    tkts_cell #(
      .KEY_BITS(KEY_BITS),
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ins_i       (accept),
      .drain_i     (drain),
      .new_key_i   (new_key),
      .new_id_i    (conn_id_i),
      .prev_take_i (prev_take),
      .prev_key_i  (prev_key),
      .prev_id_i   (prev_id),
      .prev_valid_i(prev_valid),
      .next_key_i  (next_key),
      .next_id_i   (next_id),
      .next_valid_i(next_valid),
      .take_o      (cell_take[i]),
      .key_o       (cell_key[i]),
      .id_o        (cell_id[i]),
      .valid_o     (cell_valid[i])
    );
  end

  // Collect records until the last one, then drain TOP_K slots.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_COLLECT: begin
        cnt_d = '0;
        if (accept && last_record_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cnt_q == LAST_CNT) begin
          state_d = ST_COLLECT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_COLLECT;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // The head cell is the result; empty slots read as zero.
  assign result_valid_o = drain;
  assign rank_o         = RANK_BITS'(cnt_q);
  assign slot_used_o    = cell_valid[0];
  assign ranked_id_o    = cell_valid[0] ? cell_id[0] : '0;
  assign ranked_key_o   = cell_valid[0] ? cell_key[0] : '0;
  assign last_slot_o    = drain && (cnt_q == LAST_CNT);

endmodule

FILE: rtl/core/tkts_cell.sv
`timescale 1ns / 1ps

module tkts_cell
  import tkts_pkg::*;
#(
  parameter int unsigned KEY_BITS = 49,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ins_i,
  input  logic                drain_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  input  logic                prev_take_i,
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic [ID_BITS-1:0]  prev_id_i,
  input  logic                prev_valid_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  input  logic [ID_BITS-1:0]  next_id_i,
  input  logic                next_valid_i,
  output logic                take_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [ID_BITS-1:0]  id_o,
  output logic                valid_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  logic                valid_q, valid_d;
  cell_mode_e          mode;

  // The new item belongs here or above when this slot is empty or holds a smaller key.
  assign take_o = !valid_q || (key_q < new_key_i);

  // Pick the cell's action: drain shifts toward the head, insertion shifts toward the tail.
  always_comb begin
    if (drain_i) begin
      mode = CELL_SHIFT_UP;
    end else if (ins_i && take_o && prev_take_i) begin
      mode = CELL_SHIFT_DOWN;
    end else if (ins_i && take_o) begin
      mode = CELL_LOAD_NEW;
    end else begin
      mode = CELL_HOLD;
    end
  end

  always_comb begin
    key_d   = key_q;
    id_d    = id_q;
    valid_d = valid_q;
    case (mode)
      CELL_LOAD_NEW: begin
        key_d   = new_key_i;
        id_d    = new_id_i;
        valid_d = 1'b1;
      end
      CELL_SHIFT_DOWN: begin
        key_d   = prev_key_i;
        id_d    = prev_id_i;
        valid_d = prev_valid_i;
      end
      CELL_SHIFT_UP: begin
        key_d   = next_key_i;
        id_d    = next_id_i;
        valid_d = next_valid_i;
      end
      default: begin
        key_d   = key_q;
        id_d    = id_q;
        valid_d = valid_q;
      end
    endcase
  end

  // Occupancy flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Key and identifier are payload only.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o   = key_q;
  assign id_o    = id_q;
  assign valid_o = valid_q;

endmodule

FILE: rtl/core/tkts_checker.sv
`timescale 1ns / 1ps

module tkts_checker
  import tkts_pkg::*;
#(
  parameter int unsigned ID_BITS    = 16,
  parameter int unsigned COUNT_BITS = 48
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 last_record_i,
  input logic                 result_valid_o,
  input logic [RANK_BITS-1:0] rank_o,
  input logic [ID_BITS-1:0]   ranked_id_o,
  input logic [COUNT_BITS:0]  ranked_key_o,
  input logic                 slot_used_o,
  input logic                 last_slot_o
);

  // A last record starts the readout at rank zero in the next cycle.
  a_drain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_record_i |=> result_valid_o && rank_o == '0)
    else $error("readout did not start after the last record");

  // The readout runs without gaps until the final slot.
  a_drain_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_slot_o |=> result_valid_o && rank_o == $past(rank_o) + 1'b1)
    else $error("readout broke off before the final slot");

  // The final slot ends the readout.
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_slot_o |=> !result_valid_o)
    else $error("readout continued past the final slot");

  // Records are refused while results go out.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while records are accepted");

  // An empty slot carries zero fields.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !slot_used_o |-> ranked_id_o == '0 && ranked_key_o == '0)
    else $error("empty slot carries data");

endmodule

bind top_k_traffic_selector tkts_checker #(
  .ID_BITS   (ID_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_tkts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_record_i (last_record_i),
  .result_valid_o(result_valid_o),
  .rank_o        (rank_o),
  .ranked_id_o   (ranked_id_o),
  .ranked_key_o  (ranked_key_o),
  .slot_used_o   (slot_used_o),
  .last_slot_o   (last_slot_o)
);
